[src/mwl_pkg.sv]
package mwl_pkg;

    localparam int MAX_SLOTS_DEF = 63;

    localparam logic [63:0] DEG30  = 64'd1537228672809129301;
    localparam logic [63:0] DEG60  = 64'd3074457345618258602;
    localparam logic [63:0] DEG120 = 64'd6148914691236517205;
    localparam logic [63:0] DEG180 = 64'd9223372036854775808;
    localparam logic [63:0] DEG240 = 64'd12297829382473034410;
    localparam logic [63:0] DEG300 = 64'd15372286728091293013;
    localparam logic [63:0] EPS_ANGLE = 64'd512;

    // sector codes: A,b,C,a,B,c
    localparam logic [2:0] SEC_A     = 3'd0;
    localparam logic [2:0] SEC_B_REV = 3'd1;
    localparam logic [2:0] SEC_C     = 3'd2;
    localparam logic [2:0] SEC_A_REV = 3'd3;
    localparam logic [2:0] SEC_B     = 3'd4;
    localparam logic [2:0] SEC_C_REV = 3'd5;

    // phase codes
    localparam logic [1:0] PH_A = 2'd0;
    localparam logic [1:0] PH_B = 2'd1;
    localparam logic [1:0] PH_C = 2'd2;

    typedef struct packed {
        logic [5:0] slot_count;
        logic [7:0] pole_count;
    } in_word_t;

    typedef struct packed {
        logic [1:0] phase;
        logic       reversed;
        logic [5:0] slot_index;
        logic       error;
        logic       last;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_GCD,
        ST_GCDCHK,
        ST_DIV,
        ST_MUL,
        ST_FILL,
        ST_SCAN,
        ST_FLAGS0,
        ST_FLAGS1,
        ST_FLAGS2,
        ST_EMIT,
        ST_ERR
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic gcd_init;
        logic gcd_step;
        logic div_init;
        logic div_step;
        logic mul;
        logic fill_init;
        logic fill_step;
        logic scan_init;
        logic scan_step;
        logic flags0;
        logic flags1;
        logic emit_init;
        logic emit_adv;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic basic_ok;
        logic gcd_done;
        logic gcd_ok;
        logic div_done;
        logic fill_done;
        logic scan_done;
        logic emit_last;
    } sts_t;

    function automatic logic [1:0] sec_phase(input logic [2:0] s);
        case (s)
            SEC_B_REV, SEC_B: sec_phase = PH_B;
            SEC_C, SEC_C_REV: sec_phase = PH_C;
            default:          sec_phase = PH_A;
        endcase
    endfunction

    function automatic logic sec_rev(input logic [2:0] s);
        sec_rev = (s == SEC_B_REV) || (s == SEC_A_REV) || (s == SEC_C_REV);
    endfunction

endpackage

[src/motor_winding_layout_generator_top.sv]
// Winding layout generator: one slot/pole pair in, one word per slot out, or a
// single error word. Steps: check, serial gcd/quotient, the 71-step divider, fill
// at one slot/cycle, backward scan, flags; then one word per cycle unless stalled.
// Throughput: one item at a time; a new pair is taken only once the last is done.
// Reset: async active low; controller idles, sector memory is not cleared.
module motor_winding_layout_generator_top #(
    parameter int MAX_SLOTS = mwl_pkg::MAX_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  mwl_pkg::in_word_t      in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output mwl_pkg::out_word_t     out_data
);

    mwl_pkg::cmd_t cmd;
    mwl_pkg::sts_t sts;
    logic          out_err;

    mwl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .out_err(out_err),
        .cmd(cmd), .sts(sts)
    );

    mwl_dp #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_word(in_data), .cmd(cmd), .sts(sts),
        .out_err(out_err), .out_word(out_data)
    );

endmodule

[src/mwl_ctrl.sv]
module mwl_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   out_err,
    output mwl_pkg::cmd_t          cmd,
    input  mwl_pkg::sts_t          sts
);

    mwl_pkg::state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mwl_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mwl_pkg::ST_IDLE:   if (in_valid) state_next = mwl_pkg::ST_CHECK;
            mwl_pkg::ST_CHECK:  state_next = sts.basic_ok ? mwl_pkg::ST_GCD
                                                          : mwl_pkg::ST_ERR;
            mwl_pkg::ST_GCD:    if (sts.gcd_done) state_next = mwl_pkg::ST_GCDCHK;
            mwl_pkg::ST_GCDCHK: state_next = sts.gcd_ok ? mwl_pkg::ST_DIV
                                                        : mwl_pkg::ST_ERR;
            mwl_pkg::ST_DIV:    if (sts.div_done) state_next = mwl_pkg::ST_MUL;
            mwl_pkg::ST_MUL:    state_next = mwl_pkg::ST_FILL;
            mwl_pkg::ST_FILL:   if (sts.fill_done) state_next = mwl_pkg::ST_SCAN;
            mwl_pkg::ST_SCAN:   if (sts.scan_done) state_next = mwl_pkg::ST_FLAGS0;
            mwl_pkg::ST_FLAGS0: state_next = mwl_pkg::ST_FLAGS1;
            mwl_pkg::ST_FLAGS1: state_next = mwl_pkg::ST_FLAGS2;
            mwl_pkg::ST_FLAGS2: state_next = mwl_pkg::ST_EMIT;
            mwl_pkg::ST_EMIT:
                if (!out_stall && sts.emit_last) state_next = mwl_pkg::ST_IDLE;
            mwl_pkg::ST_ERR:    if (!out_stall) state_next = mwl_pkg::ST_IDLE;
            default:            state_next = mwl_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd       = '0;
        in_stall  = 1'b1;
        out_valid = 1'b0;
        out_err   = 1'b0;
        case (state_reg)
            mwl_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            mwl_pkg::ST_CHECK:  cmd.gcd_init = 1'b1;
            mwl_pkg::ST_GCD:    cmd.gcd_step = 1'b1;
            mwl_pkg::ST_GCDCHK: cmd.div_init = 1'b1;
            mwl_pkg::ST_DIV:    cmd.div_step = 1'b1;
            mwl_pkg::ST_MUL:
            begin
                cmd.mul       = 1'b1;
                cmd.fill_init = 1'b1;
            end
            mwl_pkg::ST_FILL:
            begin
                cmd.fill_step = 1'b1;
                cmd.scan_init = sts.fill_done;
            end
            mwl_pkg::ST_SCAN:   cmd.scan_step = 1'b1;
            mwl_pkg::ST_FLAGS0: cmd.flags0 = 1'b1;
            mwl_pkg::ST_FLAGS1: cmd.flags1 = 1'b1;
            mwl_pkg::ST_FLAGS2: cmd.emit_init = 1'b1;
            mwl_pkg::ST_EMIT:
            begin
                out_valid    = 1'b1;
                cmd.emit_adv = !out_stall;
            end
            mwl_pkg::ST_ERR:
            begin
                out_valid = 1'b1;
                out_err   = 1'b1;
            end
            default: ;
        endcase
    end

endmodule

[src/mwl_dp.sv]
module mwl_dp #(
    parameter int MAX_SLOTS = mwl_pkg::MAX_SLOTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mwl_pkg::in_word_t      in_word,
    input  mwl_pkg::cmd_t          cmd,
    output mwl_pkg::sts_t          sts,
    input  logic                   out_err,
    output mwl_pkg::out_word_t     out_word
);

    localparam int AW = $clog2(MAX_SLOTS);

    logic [5:0]  slots_reg;
    logic [7:0]  poles_reg;
    // gcd by repeated subtraction
    logic [7:0]  ga_reg, ga_next, gb_reg, gb_next;
    // poles / g by subtraction
    logic [7:0]  q_reg, q_next, rq_reg, rq_next;
    logic        gphase_reg, gphase_next;
    // restoring divider (poles * 2^63) / slots
    logic [70:0] dq_reg, dq_next;
    logic [5:0]  dr_reg, dr_next;
    logic [6:0]  dcnt_reg, dcnt_next;
    logic [63:0] angle_step_reg;
    logic [63:0] angle_acc_reg;
    logic [5:0]  slot_counter_reg;
    logic [5:0]  start_offset_reg;
    logic        found_reg;
    logic        invert_reg, swap_reg;
    logic [5:0]  eidx_reg, epos_reg;
    logic [2:0]  rd_reg;
    logic [2:0]  sector_store [MAX_SLOTS];
    logic [AW-1:0] rd_addr;
    logic        rd_en;

    logic [2:0]  sec;
    logic [6:0]  dtrial;
    logic        dbit;

    // divide by 3 through reciprocal multiplication
    logic [12:0] s_x43;
    logic [5:0]  s_div3, s_mod3;
    logic [16:0] q_x171;
    logic [7:0]  q_div3, q_mod3;

    assign s_x43  = {7'd0, slots_reg} * 13'd43;
    assign s_div3 = s_x43[12:7];
    assign s_mod3 = slots_reg - (s_div3 + {s_div3[4:0], 1'b0});
    assign q_x171 = {9'd0, q_reg} * 17'd171;
    assign q_div3 = q_x171[16:9];
    assign q_mod3 = q_reg - (q_div3 + {q_div3[6:0], 1'b0});

    assign sts.basic_ok = (slots_reg != 6'd0) && (s_mod3 == 6'd0)
                          && ({26'd0, slots_reg} <= MAX_SLOTS)
                          && (poles_reg != 8'd0) && !poles_reg[0]
                          && ({2'd0, slots_reg} != poles_reg);
    assign sts.gcd_done  = gphase_reg && (rq_reg < ga_reg);
    assign sts.gcd_ok    = q_mod3 != 8'd0;
    assign sts.div_done  = dcnt_reg == 7'd0;
    assign sts.fill_done = slot_counter_reg == slots_reg - 6'd1;
    assign sts.scan_done = found_reg || slot_counter_reg == 6'd0;
    assign sts.emit_last = eidx_reg == slots_reg - 6'd1;

    // gcd, then quotient poles / g
    always_comb
    begin
        ga_next = ga_reg; gb_next = gb_reg; q_next = q_reg; rq_next = rq_reg;
        gphase_next = gphase_reg;
        if (cmd.gcd_init)
        begin
            ga_next = {2'd0, s_div3};
            gb_next = poles_reg;
            q_next  = 8'd0;
            rq_next = poles_reg;
            gphase_next = 1'b0;
        end
        else if (cmd.gcd_step)
        begin
            if (!gphase_reg)
            begin
                if (ga_reg == gb_reg) gphase_next = 1'b1;
                else if (ga_reg > gb_reg) ga_next = ga_reg - gb_reg;
                else gb_next = gb_reg - ga_reg;
            end
            else if (rq_reg >= ga_reg)
            begin
                rq_next = rq_reg - ga_reg;
                q_next  = q_reg + 8'd1;
            end
        end
    end

    // divider step
    assign dtrial = {dr_reg, dq_reg[70]};
    assign dbit   = dtrial >= {1'b0, slots_reg};
    always_comb
    begin
        dq_next = dq_reg; dr_next = dr_reg; dcnt_next = dcnt_reg;
        if (cmd.div_init)
        begin
            dq_next = {poles_reg, 63'd0}; dr_next = 6'd0; dcnt_next = 7'd71;
        end
        else if (cmd.div_step && dcnt_reg != 7'd0)
        begin
            dr_next   = dbit ? 6'(dtrial - {1'b0, slots_reg}) : dtrial[5:0];
            dq_next   = {dq_reg[69:0], dbit};
            dcnt_next = dcnt_reg - 7'd1;
        end
    end

    // sector classification of current angle
    always_comb
    begin
        if (angle_acc_reg < mwl_pkg::DEG60)       sec = mwl_pkg::SEC_A;
        else if (angle_acc_reg < mwl_pkg::DEG120) sec = mwl_pkg::SEC_B_REV;
        else if (angle_acc_reg < mwl_pkg::DEG180) sec = mwl_pkg::SEC_C;
        else if (angle_acc_reg < mwl_pkg::DEG240) sec = mwl_pkg::SEC_A_REV;
        else if (angle_acc_reg < mwl_pkg::DEG300) sec = mwl_pkg::SEC_B;
        else                                      sec = mwl_pkg::SEC_C_REV;
    end

    // memory read address; scan reads one slot ahead of the counter
    always_comb
    begin
        rd_addr = slot_counter_reg[AW-1:0];
        if (cmd.scan_step && slot_counter_reg != 6'd0)
            rd_addr = AW'(slot_counter_reg - 6'd1);
        if (cmd.flags0 || cmd.emit_init) rd_addr = start_offset_reg[AW-1:0];
        if (cmd.flags1)
            rd_addr = (start_offset_reg == 6'd0) ? AW'(slots_reg - 6'd1)
                                                 : AW'(start_offset_reg - 6'd1);
        if (cmd.emit_adv)                rd_addr = epos_reg[AW-1:0];
    end

    // read data holds while the result word is stalled
    assign rd_en = cmd.scan_init || cmd.scan_step || cmd.flags0 || cmd.flags1
                   || cmd.emit_init || cmd.emit_adv;

    // sector memory; last fill write is forwarded to the first scan read
    always_ff @(posedge clk)
    begin
        if (cmd.fill_step) sector_store[slot_counter_reg[AW-1:0]] <= sec;
        if (rd_en) rd_reg <= cmd.scan_init ? sec : sector_store[rd_addr];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gphase_reg <= 1'b0;
            dcnt_reg <= 7'd0;
            angle_step_reg <= '0;
            angle_acc_reg <= '0;
            slot_counter_reg <= '0;
            start_offset_reg <= '0;
            found_reg <= 1'b0;
            eidx_reg <= '0;
            epos_reg <= '0;
        end
        else
        begin
            gphase_reg <= gphase_next;
            dcnt_reg <= dcnt_next;
            if (cmd.mul)
                angle_step_reg <= dq_reg[63:0];
            if (cmd.fill_init)
            begin
                angle_acc_reg <= mwl_pkg::DEG30 + mwl_pkg::EPS_ANGLE;
                slot_counter_reg <= '0;
            end
            else if (cmd.fill_step)
            begin
                angle_acc_reg <= angle_acc_reg + angle_step_reg;
                if (!sts.fill_done) slot_counter_reg <= slot_counter_reg + 6'd1;
            end
            // scan backward: rd_reg holds sector of slot_counter
            if (cmd.scan_init)
            begin
                found_reg <= 1'b0;
                start_offset_reg <= 6'd0;
            end
            else if (cmd.scan_step && !found_reg)
            begin
                if (mwl_pkg::sec_phase(rd_reg) != mwl_pkg::PH_A)
                begin
                    found_reg <= 1'b1;
                    start_offset_reg <= (slot_counter_reg == slots_reg - 6'd1)
                                        ? 6'd0 : slot_counter_reg + 6'd1;
                end
                else if (slot_counter_reg != 6'd0)
                    slot_counter_reg <= slot_counter_reg - 6'd1;
            end
            if (cmd.emit_init)
            begin
                eidx_reg <= 6'd0;
                epos_reg <= (start_offset_reg == slots_reg - 6'd1)
                            ? 6'd0 : start_offset_reg + 6'd1;
            end
            else if (cmd.emit_adv)
            begin
                eidx_reg <= eidx_reg + 6'd1;
                epos_reg <= (epos_reg == slots_reg - 6'd1) ? 6'd0 : epos_reg + 6'd1;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ga_reg <= ga_next; gb_reg <= gb_next; q_reg <= q_next; rq_reg <= rq_next;
        dq_reg <= dq_next; dr_reg <= dr_next;
        if (cmd.load)
        begin
            slots_reg <= in_word.slot_count;
            poles_reg <= in_word.pole_count;
        end
        if (cmd.flags1) invert_reg <= rd_reg == mwl_pkg::SEC_A_REV;
        if (cmd.emit_init) swap_reg <= mwl_pkg::sec_phase(rd_reg) != mwl_pkg::PH_C;
    end

    // result word
    always_comb
    begin
        out_word = '0;
        if (out_err)
        begin
            out_word.error = 1'b1;
            out_word.last  = 1'b1;
        end
        else
        begin
            out_word.phase = mwl_pkg::sec_phase(rd_reg);
            if (swap_reg && out_word.phase != mwl_pkg::PH_A)
                out_word.phase = 2'd3 - out_word.phase;
            out_word.reversed   = mwl_pkg::sec_rev(rd_reg) ^ invert_reg;
            out_word.slot_index = eidx_reg;
            out_word.last       = sts.emit_last;
        end
    end

endmodule

[bench/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    // Expected output words, oldest first, checked against the block
    class layout_scoreboard;
        mwl_pkg::out_word_t pending_words[$];
        int        fail_count;

        function int gcd_of(input int a, input int b);
            int t;
            while (b != 0)
            begin
                t = a % b;
                a = b;
                b = t;
            end
            return a;
        endfunction

        // Work out the layout for one accepted input word
        function void note_input(input mwl_pkg::in_word_t w);
            int n;
            int p;
            int start;
            int last_i;
            logic [2:0] sec[64];
            logic [63:0] acc;
            logic [63:0] step;
            logic [127:0] wide;
            logic invert;
            logic swap_bc;
            logic [2:0] s;
            logic [1:0] ph;
            logic rv;
            mwl_pkg::out_word_t o;
            bit ok;
            n = w.slot_count;
            p = w.pole_count;
            ok = 1;
            if (n == 0 || n % 3 != 0 || n > 63) ok = 0;
            if (p == 0 || p % 2 != 0) ok = 0;
            if (n == p) ok = 0;
            if (ok && ((p / gcd_of(n / 3, p)) % 3 == 0)) ok = 0;
            if (!ok)
            begin
                o = '0;
                o.error = 1'b1;
                o.last = 1'b1;
                pending_words.push_back(o);
                return;
            end
            wide = ({64'd0, mwl_pkg::DEG180} * p) / n;
            step = wide[63:0];
            acc = mwl_pkg::DEG30 + mwl_pkg::EPS_ANGLE;
            for (int i = 0; i < n; i++)
            begin
                if (acc < mwl_pkg::DEG60) sec[i] = mwl_pkg::SEC_A;
                else if (acc < mwl_pkg::DEG120) sec[i] = mwl_pkg::SEC_B_REV;
                else if (acc < mwl_pkg::DEG180) sec[i] = mwl_pkg::SEC_C;
                else if (acc < mwl_pkg::DEG240) sec[i] = mwl_pkg::SEC_A_REV;
                else if (acc < mwl_pkg::DEG300) sec[i] = mwl_pkg::SEC_B;
                else sec[i] = mwl_pkg::SEC_C_REV;
                acc = acc + step;
            end
            start = 0;
            for (int k = n; k > 0; k--)
            begin
                if (sec[k-1] != mwl_pkg::SEC_A && sec[k-1] != mwl_pkg::SEC_A_REV)
                begin
                    start = k % n;
                    break;
                end
            end
            invert = (sec[start] == mwl_pkg::SEC_A_REV);
            last_i = (start + n - 1) % n;
            swap_bc = !(sec[last_i] == mwl_pkg::SEC_C || sec[last_i] == mwl_pkg::SEC_C_REV);
            for (int i = 0; i < n; i++)
            begin
                s = sec[(start + i) % n];
                case (s)
                    mwl_pkg::SEC_B_REV, mwl_pkg::SEC_B: ph = mwl_pkg::PH_B;
                    mwl_pkg::SEC_C, mwl_pkg::SEC_C_REV: ph = mwl_pkg::PH_C;
                    default:                            ph = mwl_pkg::PH_A;
                endcase
                rv = (s == mwl_pkg::SEC_B_REV) || (s == mwl_pkg::SEC_A_REV)
                     || (s == mwl_pkg::SEC_C_REV);
                rv = rv ^ invert;
                if (swap_bc && ph != mwl_pkg::PH_A) ph = 2'd3 - ph;
                o.phase = ph;
                o.reversed = rv;
                o.slot_index = i[5:0];
                o.error = 1'b0;
                o.last = (i == n - 1);
                pending_words.push_back(o);
            end
        endfunction

        function void check_output(input mwl_pkg::out_word_t got);
            mwl_pkg::out_word_t exp_w;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word %h", $realtime, got);
                fail_count++;
                return;
            end
            exp_w = pending_words.pop_front();
            if (got.phase !== exp_w.phase)
                $display("%0t: phase exp %0d got %0d", $realtime, exp_w.phase, got.phase);
            if (got.reversed !== exp_w.reversed)
                $display("%0t: reversed exp %0d got %0d", $realtime,
                         exp_w.reversed, got.reversed);
            if (got.slot_index !== exp_w.slot_index)
                $display("%0t: slot_index exp %0d got %0d", $realtime,
                         exp_w.slot_index, got.slot_index);
            if (got.error !== exp_w.error)
                $display("%0t: error exp %0d got %0d", $realtime, exp_w.error, got.error);
            if (got.last !== exp_w.last)
                $display("%0t: last exp %0d got %0d", $realtime, exp_w.last, got.last);
            if (got !== exp_w) fail_count++;
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    mwl_pkg::in_word_t  in_data;
    logic      out_valid;
    logic      out_stall;
    mwl_pkg::out_word_t out_data;

    layout_scoreboard layout_sb;
    bit        stim_done;
    bit        hold_req;
    mwl_pkg::in_word_t  directed_words[$];

    motor_winding_layout_generator_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Offer one word after a random gap; returns once accepted
    task automatic send_word(input mwl_pkg::in_word_t w);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        layout_sb.note_input(w);
    endtask

    // Mostly valid pairs, some fully random
    function automatic mwl_pkg::in_word_t random_word();
        mwl_pkg::in_word_t w;
        w.slot_count = 6'($urandom_range(0, 63));
        w.pole_count = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 8)
        begin
            if ($urandom_range(0, 5) == 0)
                w.slot_count = 6'(3 * $urandom_range(1, 21));
            else
                w.slot_count = 6'(3 * $urandom_range(1, 8));
            w.pole_count = 8'(2 * $urandom_range(1, $urandom_range(0, 3) == 0 ? 127 : 24));
        end
        return w;
    endfunction

    // Sender
    initial
    begin
        mwl_pkg::in_word_t w;
        int n_words;
        layout_sb = new();
        stim_done = 0;
        hold_req = 0;
        in_valid = 1'b0;
        in_data = '0;
        rst_n = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // directed: extremes, common layouts, each error cause
        directed_words = '{
            '{6'd12, 8'd10}, '{6'd12, 8'd14}, '{6'd9, 8'd8}, '{6'd9, 8'd10},
            '{6'd3, 8'd2}, '{6'd3, 8'd4}, '{6'd63, 8'd254}, '{6'd63, 8'd2},
            '{6'd24, 8'd22}, '{6'd36, 8'd34}, '{6'd18, 8'd16}, '{6'd6, 8'd4},
            '{6'd0, 8'd10}, '{6'd10, 8'd8}, '{6'd12, 8'd0}, '{6'd12, 8'd7},
            '{6'd12, 8'd12}, '{6'd12, 8'd6}, '{6'd6, 8'd255}, '{6'd63, 8'd0},
            '{6'd21, 8'd2}, '{6'd48, 8'd46}, '{6'd60, 8'd56}
        };
        foreach (directed_words[i]) send_word(directed_words[i]);
        n_words = 0;
        while (n_words < 240)
        begin
            if (n_words == 100) hold_req = 1;
            w = random_word();
            send_word(w);
            n_words++;
        end
        in_valid <= 1'b0;
        stim_done = 1;
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        int gap;
        out_stall = 1'b1;
        @(posedge rst_n);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 0;
                out_stall <= 1'b1;
                repeat (2000) @(posedge clk);
            end
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
            if (gap != 0)
            begin
                out_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
        end
    end

    // Monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            layout_sb.check_output(out_data);
    end

    // End of run
    initial
    begin
        @(posedge clk);
        wait (stim_done);
        while (layout_sb.pending_words.size() != 0) @(posedge clk);
        repeat (400) @(posedge clk);
        if (layout_sb.fail_count == 0 && layout_sb.pending_words.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #20000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
src/mwl_pkg.sv
src/mwl_ctrl.sv
src/mwl_dp.sv
src/motor_winding_layout_generator_top.sv
bench/testbench.sv
